// ===== src/dfs_topological_sort_top_defines.svh =====
// Assertion macros for the topological sort block.
// Both sample on the rising edge of clk and are off while rst is high.
`ifndef DFS_TOPOLOGICAL_SORT_TOP_DEFINES_SVH
`define DFS_TOPOLOGICAL_SORT_TOP_DEFINES_SVH

// Check in the same cycle: when ante holds, cons must hold.
`define DFS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dfs_topological_sort: same-cycle check failed");

// Next-cycle check: when ante holds, cons must hold at the next edge.
`define DFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dfs_topological_sort: next-cycle check failed");

`endif

// ===== src/dfs_pkg.sv =====
`default_nettype none

package dfs_pkg;

  localparam int VERTEX_W         = 6;
  localparam int VCOUNT_W         = 7;
  localparam int MAX_VERTICES_DEF = 64;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [VCOUNT_W-1:0]     VCOUNT_RESET     = 7'd64;
  localparam logic [APB_ADDR_W-3:0]   REG_VERTEX_COUNT = '0;

  typedef struct packed {
    logic                mode;
    logic [VERTEX_W-1:0] src;
    logic [VERTEX_W-1:0] dst;
  } req_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic                last;
  } rsp_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic cap_in;
    logic edge_rd;
    logic edge_wr;
    logic sort_init;
    logic root_take;
    logic descend;
    logic finish;
    logic pop_load;
    logic clear_adj;
    logic emit_rd;
    logic emit_ld;
    logic emit_next;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic root_found;
    logic cand_found;
    logic stack_empty;
    logic emit_last;
  } stat_t;

endpackage

`default_nettype wire

// ===== src/dfs_topological_sort_top.sv =====
// Depth-first topological sort.
// Request channel (req_valid/req_ready/req_data): one beat per item. With
// mode 0 the beat adds the edge src -> dst to the adjacency store; with
// mode 1 it sorts the graph of vertex_count vertices and emits the order.
// Response channel (rsp_valid/rsp_ready/rsp_data): one beat per vertex in
// reverse postorder, last set on the final beat. An edge beat gives none.
// Configuration: APB register vertex_count at byte address 0. It must be
// written only while the block is idle; the block does not check this. Zero
// acts as one, values above MAX_VERTICES act as MAX_VERTICES.
// Sequence: an edge item does a read-modify-write of its row. A sort takes
// one root step per root plus a final one, one scan step per adjacency row
// read and one pop step per stack return, all set by the single read port
// of the adjacency memory; then each result beat is read through the
// registered order memory into the output register.
// req_ready is high only when no item is in flight.
// Reset: synchronous, active high; clears the graph, returns to idle and
// sets vertex_count to 64. A stalled response holds its beat until taken.
`default_nettype none

`include "dfs_topological_sort_top_defines.svh"

module dfs_topological_sort_top #(
  parameter int MAX_VERTICES = dfs_pkg::MAX_VERTICES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  dfs_pkg::req_t                   req_data,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output dfs_pkg::rsp_t                   rsp_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dfs_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [dfs_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [dfs_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  import dfs_pkg::*;

  logic [VCOUNT_W-1:0] vertex_count;
  logic                reg_hit;
  cmd_t                cmd;
  stat_t               stat;

  // register select: word index, byte lanes ignored
  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_VERTEX_COUNT);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? APB_DATA_W'(vertex_count) : '0;

  // write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      vertex_count <= pwdata[VCOUNT_W-1:0];
    end
  end

  // sequencer: edge load, search walk, result emission
  dfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_mode  (req_data.mode),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid)
  );

  // memories, visited marks, stack pointer and output register
  dfs_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req          (req_data),
    .vertex_count (vertex_count),
    .rsp          (rsp_data)
  );

  // never take a new item while a result beat is pending
  `DFS_ASSERT_NOW(a_no_req_during_rsp, rsp_valid, !req_ready)
  // a sort always passes through the search before its first beat
  `DFS_ASSERT_NEXT(a_sort_not_instant, req_valid && req_ready && req_data.mode, !rsp_valid)
  // the final beat returns the block to idle
  `DFS_ASSERT_NEXT(a_idle_after_last, rsp_valid && rsp_ready && rsp_data.last, req_ready)
  // at most one search step per cycle
  `DFS_ASSERT_NOW(a_one_step, 1'b1, $onehot0({cmd.root_take, cmd.descend, cmd.finish, cmd.pop_load}))

endmodule

`default_nettype wire

// ===== src/dfs_ram.sv =====
`default_nettype none

module dfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/dfs_ctrl.sv =====
`default_nettype none

module dfs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_mode,
  input  logic           rsp_ready,
  input  dfs_pkg::stat_t stat,
  output dfs_pkg::cmd_t  cmd,
  output logic           req_ready,
  output logic           rsp_valid
);

  import dfs_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_EDGE_RD  = 9'b000000010,
    S_EDGE_WR  = 9'b000000100,
    S_ROOT     = 9'b000001000,
    S_SCAN     = 9'b000010000,
    S_POP      = 9'b000100000,
    S_EMIT_RD  = 9'b001000000,
    S_EMIT_LD  = 9'b010000000,
    S_EMIT_OUT = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.cap_in = 1'b1;
          if (req_mode) begin
            cmd.sort_init = 1'b1;
            state_next    = S_ROOT;
          end else begin
            state_next = S_EDGE_RD;
          end
        end
      end
      S_EDGE_RD: begin
        cmd.edge_rd = 1'b1;
        state_next  = S_EDGE_WR;
      end
      S_EDGE_WR: begin
        cmd.edge_wr = 1'b1;
        state_next  = S_IDLE;
      end
      S_ROOT: begin
        if (stat.root_found) begin
          cmd.root_take = 1'b1;
          state_next    = S_SCAN;
        end else begin
          cmd.clear_adj = 1'b1;
          state_next    = S_EMIT_RD;
        end
      end
      S_SCAN: begin
        if (stat.cand_found) begin
          cmd.descend = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          state_next = stat.stack_empty ? S_ROOT : S_POP;
        end
      end
      S_POP: begin
        cmd.pop_load = 1'b1;
        state_next   = S_SCAN;
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        state_next  = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (rsp_ready) begin
          if (stat.emit_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_next    = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_EMIT_OUT);

endmodule

`default_nettype wire

// ===== src/dfs_dp.sv =====
`default_nettype none

module dfs_dp #(
  parameter int MAX_VERTICES = dfs_pkg::MAX_VERTICES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dfs_pkg::cmd_t                 cmd,
  output dfs_pkg::stat_t                stat,
  input  dfs_pkg::req_t                 req,
  input  logic [dfs_pkg::VCOUNT_W-1:0]  vertex_count,
  output dfs_pkg::rsp_t                 rsp
);

  import dfs_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  logic [VERTEX_W-1:0]     src_q;
  logic [VERTEX_W-1:0]     dst_q;
  logic [CW-1:0]           n_q;
  logic [MAX_VERTICES-1:0] visited;
  logic [MAX_VERTICES-1:0] row_valid;
  logic                    row_valid_rd;
  logic [AW-1:0]           cur;
  logic [CW-1:0]           sp;
  logic [AW-1:0]           pos;
  logic [AW-1:0]           k;
  rsp_t                    rsp_q;

  logic [VCOUNT_W-1:0]     vc_clamp;
  logic [CW-1:0]           n_new;
  logic [MAX_VERTICES-1:0] live;
  logic [MAX_VERTICES-1:0] open_set;
  logic [MAX_VERTICES-1:0] row_data;
  logic [MAX_VERTICES-1:0] cand;
  logic [MAX_VERTICES-1:0] edge_bit;
  logic [AW-1:0]           root_idx;
  logic [AW-1:0]           next_idx;
  logic                    edge_ok;
  logic [CW-1:0]           sp_m1;
  logic [AW-1:0]           last_idx;

  logic                    adj_we;
  logic                    adj_re;
  logic [AW-1:0]           adj_raddr;
  logic [MAX_VERTICES-1:0] adj_wdata;
  logic [MAX_VERTICES-1:0] adj_rdata;
  logic                    stk_re;
  logic [AW-1:0]           stk_rdata;
  logic [AW-1:0]           ord_rdata;

  function automatic logic [AW-1:0] lowest(input logic [MAX_VERTICES-1:0] bits);
    logic [AW-1:0] idx;
    idx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = AW'(i);
      end
    end
    return idx;
  endfunction

  // effective count: zero acts as one, clamp at the store size
  always_comb begin
    if (vertex_count == '0) begin
      vc_clamp = VCOUNT_W'(1);
    end else if (vertex_count > VCOUNT_W'(MAX_VERTICES)) begin
      vc_clamp = VCOUNT_W'(MAX_VERTICES);
    end else begin
      vc_clamp = vertex_count;
    end
  end
  assign n_new = CW'(vc_clamp);

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      live[i] = (CW'(i) < n_q);
    end
  end

  assign open_set   = ~visited & live;
  assign row_data   = row_valid_rd ? adj_rdata : '0;
  assign cand       = row_data & open_set;
  assign root_idx   = lowest(open_set);
  assign next_idx   = lowest(cand);
  assign sp_m1      = sp - 1'b1;
  assign last_idx   = AW'(n_q - 1'b1);

  assign edge_ok  = ({1'b0, src_q} < (VERTEX_W + 1)'(MAX_VERTICES)) &&
                    ({1'b0, dst_q} < (VERTEX_W + 1)'(MAX_VERTICES));
  assign edge_bit = {{(MAX_VERTICES - 1){1'b0}}, 1'b1} << dst_q;

  assign adj_we    = cmd.edge_wr & edge_ok;
  assign adj_wdata = row_data | edge_bit;
  assign adj_re    = cmd.edge_rd | cmd.root_take | cmd.descend | cmd.pop_load;

  // read the source row for an edge write, or the row that the next scan cycle needs
  always_comb begin
    if (cmd.edge_rd) begin
      adj_raddr = src_q[AW-1:0];
    end else if (cmd.root_take) begin
      adj_raddr = root_idx;
    end else if (cmd.descend) begin
      adj_raddr = next_idx;
    end else if (cmd.pop_load) begin
      adj_raddr = stk_rdata;
    end else begin
      adj_raddr = cur;
    end
  end

  assign stk_re = cmd.finish & (sp != '0);

  dfs_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj (
    .clk   (clk),
    .we    (adj_we),
    .waddr (src_q[AW-1:0]),
    .wdata (adj_wdata),
    .re    (adj_re),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  dfs_ram #(.WIDTH(AW), .DEPTH(MAX_VERTICES)) u_stack (
    .clk   (clk),
    .we    (cmd.descend),
    .waddr (sp[AW-1:0]),
    .wdata (cur),
    .re    (stk_re),
    .raddr (sp_m1[AW-1:0]),
    .rdata (stk_rdata)
  );

  dfs_ram #(.WIDTH(AW), .DEPTH(MAX_VERTICES)) u_order (
    .clk   (clk),
    .we    (cmd.finish),
    .waddr (pos),
    .wdata (cur),
    .re    (cmd.emit_rd),
    .raddr (k),
    .rdata (ord_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      visited   <= '0;
      row_valid <= '0;
    end else begin
      if (cmd.sort_init) begin
        visited <= '0;
      end
      if (cmd.root_take) begin
        visited[root_idx] <= 1'b1;
      end
      if (cmd.descend) begin
        visited[next_idx] <= 1'b1;
      end
      if (adj_we) begin
        row_valid[src_q[AW-1:0]] <= 1'b1;
      end
      if (cmd.clear_adj) begin
        row_valid <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      src_q <= req.src;
      dst_q <= req.dst;
    end
    if (adj_re) begin
      row_valid_rd <= row_valid[adj_raddr];
    end
    if (cmd.sort_init) begin
      n_q <= n_new;
      sp  <= '0;
      pos <= AW'(n_new - 1'b1);
      k   <= '0;
    end
    if (cmd.root_take) begin
      cur <= root_idx;
    end
    if (cmd.descend) begin
      cur <= next_idx;
      sp  <= sp + 1'b1;
    end
    if (cmd.finish) begin
      pos <= pos - 1'b1;
      if (sp != '0) begin
        sp <= sp_m1;
      end
    end
    if (cmd.pop_load) begin
      cur <= stk_rdata;
    end
    if (cmd.emit_ld) begin
      rsp_q.vertex <= VERTEX_W'(ord_rdata);
      rsp_q.last   <= (k == last_idx);
    end
    if (cmd.emit_next) begin
      k <= k + 1'b1;
    end
  end

  assign stat.root_found  = |open_set;
  assign stat.cand_found  = |cand;
  assign stat.stack_empty = (sp == '0);
  assign stat.emit_last   = rsp_q.last;
  assign rsp              = rsp_q;

endmodule

`default_nettype wire

// ===== verif/tb_dfs_topological_sort_top.sv =====
`timescale 1ns / 1ps

module tb_dfs_topological_sort_top;
  import dfs_pkg::*;

  // Byte address of the vertex count register on the APB port
  localparam logic [APB_ADDR_W-1:0] VCOUNT_ADDR = {REG_VERTEX_COUNT, 2'b00};
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 37;
  localparam int SETTLE      = 72;
  localparam int GRAPH_ROWS  = 64;

  // Reverse-postorder predictor and the store of vertices still to arrive
  class topo_order_checker;
    bit [63:0]           rows [GRAPH_ROWS];
    bit [VCOUNT_W-1:0]   vcount;
    rsp_t                order_due [$];
    int                  failures;

    function new();
      foreach (rows[i]) rows[i] = '0;
      vcount   = VCOUNT_RESET;
      failures = 0;
    endfunction

    function void set_count(bit [VCOUNT_W-1:0] value);
      vcount = value;
    endfunction

    // Zero behaves as one, anything past the store as the store size
    function int live_count();
      if (vcount == 0) return 1;
      if (vcount > GRAPH_ROWS) return GRAPH_ROWS;
      return vcount;
    endfunction

    function int pending();
      return order_due.size();
    endfunction

    function void note_item(req_t item);
      bit [63:0]            live;
      bit [63:0]            seen;
      bit [63:0]            cand;
      bit [VERTEX_W-1:0]    stack_vertex [GRAPH_ROWS];
      int                   stack_next [GRAPH_ROWS];
      bit [VERTEX_W-1:0]    order [GRAPH_ROWS];
      int                   n, depth, pos, w, v;
      rsp_t                 beat;
      if (item.mode == 1'b0) begin
        rows[item.src][item.dst] = 1'b1;
        return;
      end
      n     = live_count();
      live  = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
      seen  = '0;
      pos   = n - 1;
      for (int root = 0; root < n; root++) begin
        if (seen[root]) continue;
        seen[root]      = 1'b1;
        stack_vertex[0] = VERTEX_W'(root);
        stack_next[0]   = 0;
        depth           = 1;
        while (depth > 0) begin
          v    = stack_vertex[depth-1];
          cand = rows[v] & ~seen & live;
          w    = 64;
          for (int i = stack_next[depth-1]; i < 64; i++) begin
            if (cand[i]) begin
              w = i;
              break;
            end
          end
          if (w < 64) begin
            // descend into the lowest unvisited neighbour
            stack_next[depth-1] = w + 1;
            seen[w]             = 1'b1;
            stack_vertex[depth] = VERTEX_W'(w);
            stack_next[depth]   = 0;
            depth++;
          end else begin
            // finished: place from the back of the order
            depth--;
            order[pos] = VERTEX_W'(v);
            pos--;
          end
        end
      end
      for (int k = 0; k < n; k++) begin
        beat.vertex = order[k];
        beat.last   = (k == n - 1);
        order_due.push_back(beat);
      end
      foreach (rows[i]) rows[i] = '0;
    endfunction

    function void check_beat(rsp_t got);
      rsp_t want;
      if (order_due.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected beat: vertex %0d last %0b", got.vertex, got.last);
        return;
      end
      want = order_due.pop_front();
      if (got.vertex !== want.vertex || got.last !== want.last) begin
        failures++;
        if (failures <= 10)
          $display("order mismatch: vertex exp %0d got %0d, last exp %0b got %0b",
                   want.vertex, got.vertex, want.last, got.last);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  req_valid;
  logic                  req_ready;
  req_t                  req_data;
  logic                  rsp_valid;
  logic                  rsp_ready;
  rsp_t                  rsp_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int                    tx_gap_pct;
  int                    rx_stall_pct;
  topo_order_checker     board;

  dfs_topological_sort_top DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 4 ns clock, high then low
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop in case the block hangs or loses beats
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Response side: stall at random, change only on the falling edge
  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Take each response beat at the rising edge and compare it
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) board.check_beat(rsp_data);
  end

  function automatic req_t make_req(bit mode, int src, int dst);
    req_t item;
    item.mode = mode;
    item.src  = VERTEX_W'(src);
    item.dst  = VERTEX_W'(dst);
    return item;
  endfunction

  // Present one beat, with a random gap first; hold valid until it is taken
  task automatic send_item(req_t item);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      @(negedge clk);
      req_valid     = 1'b0;
      req_data.mode = 1'($urandom);
      req_data.src  = VERTEX_W'($urandom);
      req_data.dst  = VERTEX_W'($urandom);
    end
    @(negedge clk);
    req_valid = 1'b1;
    req_data  = item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    board.note_item(item);
  endtask

  task automatic send_edge(int src, int dst);
    send_item(make_req(1'b0, src, dst));
  endtask

  // Sort beat: src and dst carry junk, the block must ignore them
  task automatic send_sort();
    send_item(make_req(1'b1, $urandom_range(0, 63), $urandom_range(0, 63)));
  endtask

  // Drop valid and hold off until every expected vertex has come back
  task automatic wait_for_order();
    @(negedge clk);
    req_valid = 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Full idle: drained, ready again, and past any clearing of the graph
  task automatic settle_idle();
    wait_for_order();
    while (!req_ready) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_count(bit [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = VCOUNT_ADDR;
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.set_count(value[VCOUNT_W-1:0]);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_idling(int pattern);
    case (pattern)
      0: begin
        tx_gap_pct   = 8;
        rx_stall_pct = 73;
      end
      1: begin
        tx_gap_pct   = 73;
        rx_stall_pct = 8;
      end
      default: begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end
    endcase
  endtask

  initial begin
    int phase_counts [PHASES];
    int rank [GRAPH_ROWS];
    int n_eff, spent, shape, n_edges, u, w, j, tmp;

    phase_counts = '{64, 5, 127, 1, 12, 0, 64, 2, 0};
    board     = new();
    rst       = 1'b1;
    req_valid = 1'b0;
    req_data  = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    set_idling(0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset count of 64, empty graph gives the plain reverse order
    send_sort();
    // cycle through the extremes, a self loop and a repeated edge
    send_edge(0, 63);
    send_edge(63, 1);
    send_edge(1, 0);
    send_edge(5, 5);
    send_edge(0, 63);
    send_edge(42, 21);
    send_sort();

    // Small graph; junk above bit 6 must be dropped by the register
    settle_idle();
    write_count(32'hFFFF_FF84);
    send_edge(2, 1);
    send_edge(1, 0);
    send_edge(3, 45);   // target beyond the count: never followed
    send_edge(50, 2);   // row beyond the count: never used
    send_edge(3, 3);
    send_sort();

    // Zero acts as a single vertex
    settle_idle();
    write_count(32'd0);
    send_edge(0, 0);
    send_sort();

    // Above the store size acts as the full store
    settle_idle();
    write_count(32'd127);
    send_edge(62, 63);
    send_edge(63, 62);
    send_sort();

    settle_idle();
    write_count(32'd1);
    send_sort();

    // Random graphs: mostly acyclic with shuffled ranks, some cyclic, some noise
    phase_counts[PHASES-1] = $urandom_range(2, 63);
    for (int phase = 0; phase < PHASES; phase++) begin
      settle_idle();
      set_idling(phase / 3);
      write_count(phase_counts[phase]);
      n_eff = board.live_count();
      spent = 0;
      while (spent < PHASE_ITEMS) begin
        shape = $urandom_range(0, 9);
        for (int i = 0; i < GRAPH_ROWS; i++) rank[i] = i;
        for (int i = n_eff - 1; i > 0; i--) begin
          j       = $urandom_range(0, i);
          tmp     = rank[i];
          rank[i] = rank[j];
          rank[j] = tmp;
        end
        n_edges = (shape == 9) ? 0 :
                  $urandom_range(0, (n_eff < 20) ? 2 * n_eff : 40);
        for (int e = 0; e < n_edges; e++) begin
          u = $urandom_range(0, n_eff - 1);
          w = $urandom_range(0, n_eff - 1);
          if (shape <= 6 && rank[u] > rank[w]) begin
            tmp = u;
            u   = w;
            w   = tmp;
          end else if (shape == 8) begin
            u = $urandom_range(0, 63);
            w = $urandom_range(0, 63);
          end
          // now and then point past the live vertices
          if ($urandom_range(0, 7) == 0) begin
            if ($urandom_range(0, 1)) u = $urandom_range(0, 63);
            else w = $urandom_range(0, 63);
          end
          send_edge(u, w);
          spent++;
        end
        send_sort();
        spent++;
        // sometimes hold the sender until the whole order has drained
        if ($urandom_range(0, 4) == 0) wait_for_order();
      end
    end

    // Drain, then give the block time to clear its graph
    settle_idle();
    if (board.failures == 0 && board.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/dfs_pkg.sv
src/dfs_ram.sv
src/dfs_ctrl.sv
src/dfs_dp.sv
src/dfs_topological_sort_top.sv
verif/tb_dfs_topological_sort_top.sv
